// ===== hw/rtl/greedy_weighted_completion_scheduler_unit_macros.svh =====
// Assertion macros for the weighted completion scheduler checker.
// Included by the checker file only; no other dependencies.
`ifndef GREEDY_WEIGHTED_COMPLETION_SCHEDULER_UNIT_MACROS_SVH
`define GREEDY_WEIGHTED_COMPLETION_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GWCS_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gwcs assertion failed");

// Next-cycle implication, disabled during reset
`define GWCS_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gwcs assertion failed");

`endif

// ===== hw/rtl/gwcs_pkg.sv =====
// Shared types for the weighted completion scheduler.
// Command and status bundles between controller and datapath; no dependencies.
`default_nettype none

package gwcs_pkg;

    localparam int JOB_W = 16;
    localparam int SUM_W = 63;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic sort_init;
        logic run_start;
        logic rd_right;
        logic latch_l;
        logic latch_r;
        logic cmp;
        logic sel;
        logic next_run;
        logic next_pass;
        logic walk_init;
        logic walk_rd;
        logic walk_latch;
        logic walk_mul;
        logic walk_add;
        logic out_load;
    } gwcs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic single_job;
        logic have_right;
        logic take_r;
        logic left_more;
        logic right_more;
        logic run_end;
        logic pass_end;
        logic sort_end;
        logic walk_end;
        logic out_busy;
    } gwcs_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gwcs_datapath.sv =====
// Datapath: job stores (two ping-pong memories), merge pointers, comparator,
// completion-time walk with saturating accumulator, output register. Uses gwcs_pkg.
`default_nettype none

module gwcs_datapath import gwcs_pkg::*; #(
    parameter int MAX_JOBS = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gwcs_cmd_t          cmd,
    output gwcs_sts_t               sts,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic [2*JOB_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [63:0]             m_tdata,
    output logic                    m_tuser
);

    localparam int AW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW  = AW + 2;
    localparam int CTW = JOB_W + AW;
    localparam int TW  = JOB_W + CTW;
    localparam int DW  = 2 * JOB_W;

    // Job stores, word = {length, weight}
    logic [DW-1:0] mem0 [MAX_JOBS];
    logic [DW-1:0] mem1 [MAX_JOBS];
    logic [DW-1:0] rd0_reg, rd1_reg;

    logic [AW:0]      count_reg;
    logic             dropped_reg, mode_reg, parity_reg;
    logic [CW-1:0]    width_reg, lo_reg, mid_reg, hi_reg, l_reg, r_reg, k_reg;
    logic [DW-1:0]    hl_reg, hr_reg;
    logic             before_reg;
    logic [CTW-1:0]   ct_reg;
    logic [JOB_W-1:0] w_reg;
    logic [TW-1:0]    term_reg;
    logic [SUM_W-1:0] acc_reg;
    logic             sat_reg;
    logic [AW:0]      i_reg;
    logic             mvalid_reg;
    logic [SUM_W-1:0] msum_reg;
    logic             mflag_reg;

    logic [CW-1:0] n_ext, lo_w, lo_2w, mid_c, hi_c, width2;
    logic          la, ra, take_r, store_ok;
    logic [CW-1:0] raddr_c;
    logic [DW-1:0] rd_c, wdata_c;
    logic signed [JOB_W:0] dl, dr;
    logic [DW-1:0] pr, pl;
    logic [63:0]   sum64;

    assign n_ext    = {1'b0, count_reg};
    assign width2   = width_reg << 1;
    assign lo_w     = lo_reg + width_reg;
    assign lo_2w    = lo_reg + width2;
    assign mid_c    = (lo_w < n_ext) ? lo_w : n_ext;
    assign hi_c     = (lo_2w < n_ext) ? lo_2w : n_ext;
    assign la       = l_reg < mid_reg;
    assign ra       = r_reg < hi_reg;
    assign take_r   = ra && (!la || before_reg);
    assign store_ok = count_reg < (AW+1)'(MAX_JOBS);
    assign rd_c     = parity_reg ? rd1_reg : rd0_reg;
    assign wdata_c  = take_r ? hr_reg : hl_reg;

    // Status toward the controller
    always_comb begin
        sts.single_job = count_reg < (AW+1)'(2);
        sts.have_right = r_reg < hi_reg;
        sts.take_r     = take_r;
        sts.left_more  = (l_reg + CW'(1)) < mid_reg;
        sts.right_more = (r_reg + CW'(1)) < hi_reg;
        sts.run_end    = (k_reg + CW'(1)) == hi_reg;
        sts.pass_end   = lo_2w >= n_ext;
        sts.sort_end   = width2 >= n_ext;
        sts.walk_end   = (i_reg + (AW+1)'(1)) == count_reg;
        sts.out_busy   = mvalid_reg && !m_tready;
    end

    // Read address: next head of the consumed side, right head, walk index, or left head
    always_comb begin
        if (cmd.sel) begin
            raddr_c = take_r ? (r_reg + CW'(1)) : (l_reg + CW'(1));
        end else if (cmd.rd_right) begin
            raddr_c = r_reg;
        end else if (cmd.walk_rd) begin
            raddr_c = {1'b0, i_reg};
        end else begin
            raddr_c = l_reg;
        end
    end

    // Memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if ((cmd.load && store_ok) || (cmd.sel && parity_reg)) begin
            mem0[cmd.load ? count_reg[AW-1:0] : k_reg[AW-1:0]] <= cmd.load ? s_tdata : wdata_c;
        end
        if (cmd.sel && !parity_reg) begin
            mem1[k_reg[AW-1:0]] <= wdata_c;
        end
        rd0_reg <= mem0[raddr_c[AW-1:0]];
        rd1_reg <= mem1[raddr_c[AW-1:0]];
    end

    // Ordering key: does the right head go strictly before the left head
    assign dl = $signed({1'b0, hl_reg[JOB_W-1:0]}) - $signed({1'b0, hl_reg[DW-1:JOB_W]});
    assign dr = $signed({1'b0, hr_reg[JOB_W-1:0]}) - $signed({1'b0, hr_reg[DW-1:JOB_W]});
    assign pr = DW'(hr_reg[JOB_W-1:0]) * DW'(hl_reg[DW-1:JOB_W]);
    assign pl = DW'(hl_reg[JOB_W-1:0]) * DW'(hr_reg[DW-1:JOB_W]);

    assign sum64 = {1'b0, acc_reg} + 64'(term_reg);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            mode_reg    <= 1'b0;
            mvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                if (store_ok) begin
                    count_reg <= count_reg + (AW+1)'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                mvalid_reg  <= 1'b1;
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    // Merge and walk registers
    always_ff @(posedge aclk) begin
        if (cmd.sort_init) begin
            width_reg  <= CW'(1);
            lo_reg     <= '0;
            parity_reg <= 1'b0;
        end
        if (cmd.run_start) begin
            mid_reg <= mid_c;
            hi_reg  <= hi_c;
            l_reg   <= lo_reg;
            r_reg   <= mid_c;
            k_reg   <= lo_reg;
        end
        if (cmd.latch_l) begin
            hl_reg <= rd_c;
        end
        if (cmd.latch_r) begin
            hr_reg <= rd_c;
        end
        if (cmd.cmp) begin
            if (mode_reg) begin
                before_reg <= pr > pl;
            end else begin
                before_reg <= (dr > dl) ||
                              ((dr == dl) && (hr_reg[JOB_W-1:0] > hl_reg[JOB_W-1:0]));
            end
        end
        if (cmd.sel) begin
            k_reg <= k_reg + CW'(1);
            if (take_r) begin
                r_reg <= r_reg + CW'(1);
            end else begin
                l_reg <= l_reg + CW'(1);
            end
        end
        if (cmd.next_run) begin
            lo_reg <= lo_2w;
        end
        if (cmd.next_pass) begin
            lo_reg     <= '0;
            width_reg  <= width2;
            parity_reg <= !parity_reg;
        end
        if (cmd.walk_init) begin
            i_reg   <= '0;
            ct_reg  <= '0;
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        if (cmd.walk_latch) begin
            ct_reg <= ct_reg + CTW'(rd_c[DW-1:JOB_W]);
            w_reg  <= rd_c[JOB_W-1:0];
        end
        if (cmd.walk_mul) begin
            term_reg <= TW'(w_reg) * TW'(ct_reg);
        end
        // saturating accumulate: acc never exceeds 2^63-1, so bit 63 flags overflow
        if (cmd.walk_add) begin
            i_reg <= i_reg + (AW+1)'(1);
            if (sum64[63]) begin
                acc_reg <= '1;
                sat_reg <= 1'b1;
            end else begin
                acc_reg <= sum64[SUM_W-1:0];
            end
        end
        if (cmd.out_load) begin
            msum_reg  <= acc_reg;
            mflag_reg <= dropped_reg || sat_reg;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {1'b0, msum_reg};
    assign m_tuser  = mflag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gwcs_ctrl.sv =====
// Controller: sequences loading, bottom-up merge passes, the completion-time
// walk and result hand-off. Uses gwcs_pkg command/status types.
`default_nettype none

module gwcs_ctrl import gwcs_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic      s_tlast,
    input  wire gwcs_sts_t sts,
    output gwcs_cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SORT_INIT = 4'd1;
    localparam logic [3:0] ST_RUN_START = 4'd2;
    localparam logic [3:0] ST_FETCH_L   = 4'd3;
    localparam logic [3:0] ST_LATCH_L0  = 4'd4;
    localparam logic [3:0] ST_LATCH_L   = 4'd5;
    localparam logic [3:0] ST_LATCH_R   = 4'd6;
    localparam logic [3:0] ST_CMP       = 4'd7;
    localparam logic [3:0] ST_SEL       = 4'd8;
    localparam logic [3:0] ST_WALK_INIT = 4'd9;
    localparam logic [3:0] ST_WREAD     = 4'd10;
    localparam logic [3:0] ST_WLATCH    = 4'd11;
    localparam logic [3:0] ST_WMUL      = 4'd12;
    localparam logic [3:0] ST_WADD      = 4'd13;
    localparam logic [3:0] ST_OUT       = 4'd14;

    logic [3:0] state_reg, state_next;

    assign s_tready = state_reg == ST_IDLE;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        state_next = ST_SORT_INIT;
                    end
                end
            end
            ST_SORT_INIT: begin
                cmd.sort_init = 1'b1;
                state_next = sts.single_job ? ST_WALK_INIT : ST_RUN_START;
            end
            ST_RUN_START: begin
                cmd.run_start = 1'b1;
                state_next = ST_FETCH_L;
            end
            ST_FETCH_L: begin
                state_next = ST_LATCH_L0;
            end
            ST_LATCH_L0: begin
                cmd.latch_l = 1'b1;
                if (sts.have_right) begin
                    cmd.rd_right = 1'b1;
                    state_next = ST_LATCH_R;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_LATCH_L: begin
                cmd.latch_l = 1'b1;
                state_next = ST_CMP;
            end
            ST_LATCH_R: begin
                cmd.latch_r = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp = 1'b1;
                state_next = ST_SEL;
            end
            ST_SEL: begin
                cmd.sel = 1'b1;
                if (sts.run_end) begin
                    if (sts.pass_end) begin
                        cmd.next_pass = 1'b1;
                        state_next = sts.sort_end ? ST_WALK_INIT : ST_RUN_START;
                    end else begin
                        cmd.next_run = 1'b1;
                        state_next = ST_RUN_START;
                    end
                end else if (sts.take_r) begin
                    state_next = sts.right_more ? ST_LATCH_R : ST_CMP;
                end else begin
                    state_next = sts.left_more ? ST_LATCH_L : ST_CMP;
                end
            end
            ST_WALK_INIT: begin
                cmd.walk_init = 1'b1;
                state_next = ST_WREAD;
            end
            ST_WREAD: begin
                cmd.walk_rd = 1'b1;
                state_next = ST_WLATCH;
            end
            ST_WLATCH: begin
                cmd.walk_latch = 1'b1;
                state_next = ST_WMUL;
            end
            ST_WMUL: begin
                cmd.walk_mul = 1'b1;
                state_next = ST_WADD;
            end
            ST_WADD: begin
                cmd.walk_add = 1'b1;
                state_next = sts.walk_end ? ST_OUT : ST_WREAD;
            end
            ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/greedy_weighted_completion_scheduler_unit.sv =====
// Loading: one job per cycle while idle (s_tready high). After the transfer marked last,
// n stored jobs are merge-sorted over ceil(log2 n) passes, each element going through
// compare then select-write (single read port per store), and are then walked job by
// job (read, latch, multiply, accumulate) until the result is shown.
// Reset: synchronous, active low; clears control state and job count. Store
// contents are not cleared and no clearing pass runs.
`default_nettype none

module greedy_weighted_completion_scheduler_unit import gwcs_pkg::*; #(
    parameter int MAX_JOBS = 1024
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_data,   // sort_mode
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,       // [15:0] job_weight, [31:16] job_length
    input  wire logic         s_tlast,       // last_job
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,       // [62:0] weighted_sum, [63] zero
    output logic              m_tuser        // overflow
);

    gwcs_cmd_t cmd;
    gwcs_sts_t sts;

    // Sequencer
    gwcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stores, sort and accumulate
    gwcs_datapath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gwcs_checker.sv =====
// Port-level checker for the scheduler, attached by bind below.
// Uses the assertion macros header.
`default_nettype none
`include "greedy_weighted_completion_scheduler_unit_macros.svh"

module gwcs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // result held until taken
    `GWCS_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // sum never exceeds 63 bits
    `GWCS_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, !m_tdata[63])
    // last job transfer starts the sort, input closes
    `GWCS_ASSERT_NXT(a_close_in, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
    // no result appears right after the last transfer
    `GWCS_ASSERT_NXT(a_no_early, aclk, aresetn, s_tvalid && s_tready && s_tlast, !$rose(m_tvalid))

endmodule

bind greedy_weighted_completion_scheduler_unit gwcs_checker u_chk (.*);

`default_nettype wire
